// ===== rtl/pwmi_pkg.sv =====
// shared types and constants for the pid controller with measured interval
`timescale 1ns / 1ps
`default_nettype none
package pwmi_pkg;

  localparam int TILT_W  = 16;
  localparam int US_W    = 24;
  localparam int GAIN_W  = 32;
  localparam int DRIVE_W = 32;
  localparam int IDX_W   = 2;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D = 2'd2;

  localparam logic [19:0] US_PER_SEC  = 20'd1000000;
  localparam logic [19:0] LONG_GAP_US = 20'd1000;
  localparam logic [23:0] US_LIMIT    = 24'd1000000;

  localparam logic [61:0] TERM_LIM = 62'h2000_0000_0000_0000;
  localparam logic [63:0] RATE_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HI_LIM   = 64'h0020_0000_0000_0000;

  // two quotient bits per cycle over a 68 bit dividend
  localparam logic [5:0] DIV_LAST = 6'd33;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_TAKE_P,
    ST_N1_HI,
    ST_N1_ADD,
    ST_DIV_INT,
    ST_INTEG,
    ST_IMAG,
    ST_M24_LO,
    ST_M24_HI,
    ST_M24_SAT,
    ST_ACC,
    ST_N2_LO,
    ST_N2_HI,
    ST_N2_ADD,
    ST_DIV_RATE,
    ST_RATE,
    ST_FINISH
  } pwmi_state_t;

endpackage
`default_nettype wire

// ===== rtl/pwmi_in_if.sv =====
// input item channel: target and measured tilt, elapsed interval
`timescale 1ns / 1ps
`default_nettype none
interface pwmi_in_if;
  import pwmi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TILT_W-1:0] target_tilt;
  logic signed [TILT_W-1:0] measured_tilt;
  logic        [US_W-1:0]   elapsed_us;

  modport source (output valid, output target_tilt, output measured_tilt,
                  output elapsed_us, input ready);
  modport sink (input valid, input target_tilt, input measured_tilt,
                input elapsed_us, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwmi_out_if.sv =====
// result channel: motor drive value
`timescale 1ns / 1ps
`default_nettype none
interface pwmi_out_if;
  import pwmi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwmi_cfg_if.sv =====
// configuration write channel: register index and write data
`timescale 1ns / 1ps
`default_nettype none
interface pwmi_cfg_if;
  import pwmi_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [GAIN_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pid_with_measured_interval.sv =====
// pid controller with measured interval, one shared multiplier and divider
//
// in_chan carries target tilt, measured tilt (signed Q8.8) and the microseconds
// since the previous item; out_chan returns one signed 32 bit drive per item.
// cfg_chan writes gain_p (index 0), gain_i (1) and gain_d (2), signed Q16.16;
// it is always ready and other indexes are dropped. Write gains while idle.
// An item goes from its transfer through the sequencer to its result in the
// output register, and a new item is taken only once the sequencer is back
// in idle. The sequencer runs two 68 bit divisions (two quotient bits per
// cycle) and nine passes through one 32x32 multiplier with a registered
// product. in_chan.ready is high only while the sequencer is idle.
// The output register lets the next item start while a result waits; if the
// receiver still stalls when the next result is due, the sequencer holds.
// Synchronous active-low reset clears the gains, the integral sum, the stored
// proportional value and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module pid_with_measured_interval (
  input  wire          clk,
  input  wire          rst_n,
  pwmi_in_if.sink      in_chan,
  pwmi_out_if.source   out_chan,
  pwmi_cfg_if.sink     cfg_chan
);
  import pwmi_pkg::*;

  pwmi_state_t state_r, state_nxt;

  logic signed [31:0] gain_p_r, gain_p_nxt;
  logic signed [31:0] gain_i_r, gain_i_nxt;
  logic signed [31:0] gain_d_r, gain_d_nxt;
  logic signed [63:0] integral_r, integral_nxt;
  logic signed [47:0] last_p_r, last_p_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic        [15:0] e_mag_r, e_mag_nxt;
  logic               e_neg_r, e_neg_nxt;
  logic        [19:0] us_r, us_nxt;
  logic        [46:0] p_mag_r, p_mag_nxt;
  logic               p_neg_r, p_neg_nxt;
  logic signed [47:0] p_s_r, p_s_nxt;
  logic signed [48:0] dp_r, dp_nxt;
  logic        [47:0] dp_mag_r, dp_mag_nxt;
  logic               dp_neg_r, dp_neg_nxt;
  logic        [67:0] acc_r, acc_nxt;
  logic        [19:0] rem_r, rem_nxt;
  logic        [19:0] div_r, div_nxt;
  logic        [5:0]  cnt_r, cnt_nxt;
  logic        [63:0] opa_r, opa_nxt;
  logic        [39:0] lo_r, lo_nxt;
  logic        [61:0] term_r, term_nxt;
  logic               tneg_r, tneg_nxt;
  logic               term_d_r, term_d_nxt;
  logic signed [63:0] sum_r, sum_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic        [63:0] prod_r;

  logic [31:0] mul_a, mul_b;
  logic [31:0] gp_mag, gi_mag, gd_mag;
  logic        in_xfer, out_xfer, cfg_xfer;

  logic [20:0] t1, t2, r1, r2;
  logic        ge1, ge2;
  logic [16:0] e17;
  logic [64:0] isum;
  logic [62:0] r63;
  logic [63:0] smag;
  logic [47:0] mq;
  logic [63:0] tval;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign cfg_xfer = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.drive = drive_r;

  assign gp_mag = gain_p_r[31] ? 32'(-gain_p_r) : 32'(gain_p_r);
  assign gi_mag = gain_i_r[31] ? 32'(-gain_i_r) : 32'(gain_i_r);
  assign gd_mag = gain_d_r[31] ? 32'(-gain_d_r) : 32'(gain_d_r);

  // divider step, two bits per cycle
  assign t1  = {rem_r, acc_r[67]};
  assign ge1 = t1 >= {1'b0, div_r};
  assign r1  = ge1 ? (t1 - {1'b0, div_r}) : t1;
  assign t2  = {r1[19:0], acc_r[66]};
  assign ge2 = t2 >= {1'b0, div_r};
  assign r2  = ge2 ? (t2 - {1'b0, div_r}) : t2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    integral_nxt  = integral_r;
    last_p_nxt    = last_p_r;
    out_valid_nxt = out_valid_r;
    e_mag_nxt     = e_mag_r;
    e_neg_nxt     = e_neg_r;
    us_nxt        = us_r;
    p_mag_nxt     = p_mag_r;
    p_neg_nxt     = p_neg_r;
    p_s_nxt       = p_s_r;
    dp_nxt        = dp_r;
    dp_mag_nxt    = dp_mag_r;
    dp_neg_nxt    = dp_neg_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    opa_nxt       = opa_r;
    lo_nxt        = lo_r;
    term_nxt      = term_r;
    tneg_nxt      = tneg_r;
    term_d_nxt    = term_d_r;
    sum_nxt       = sum_r;
    drive_nxt     = drive_r;
    mul_a         = 32'd0;
    mul_b         = 32'd0;
    e17           = 17'd0;
    isum          = 65'd0;
    r63           = 63'd0;
    smag          = 64'd0;
    mq            = 48'd0;
    tval          = 64'd0;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_xfer) begin
      unique case (cfg_chan.index)
        REG_GAIN_P: gain_p_nxt = $signed(cfg_chan.data);
        REG_GAIN_I: gain_i_nxt = $signed(cfg_chan.data);
        REG_GAIN_D: gain_d_nxt = $signed(cfg_chan.data);
        default: ;
      endcase
    end

    unique case (state_r) inside
      ST_IDLE: begin
        if (in_xfer) begin
          e17 = {in_chan.target_tilt[15], in_chan.target_tilt}
              - {in_chan.measured_tilt[15], in_chan.measured_tilt};
          e_neg_nxt = e17[16];
          e_mag_nxt = e17[16] ? 16'(-e17) : e17[15:0];
          if (in_chan.elapsed_us > US_LIMIT) begin
            us_nxt = LONG_GAP_US;
          end else if (in_chan.elapsed_us == 24'd0) begin
            us_nxt = 20'd1;
          end else begin
            us_nxt = in_chan.elapsed_us[19:0];
          end
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        mul_a     = {16'd0, e_mag_r};
        mul_b     = gp_mag;
        state_nxt = ST_TAKE_P;
      end
      ST_TAKE_P: begin
        p_mag_nxt = prod_r[46:0];
        p_neg_nxt = e_neg_r ^ gain_p_r[31];
        p_s_nxt   = (e_neg_r ^ gain_p_r[31]) ? -$signed({1'b0, prod_r[46:0]})
                                             : $signed({1'b0, prod_r[46:0]});
        mul_a     = prod_r[31:0];
        mul_b     = {12'd0, us_r};
        state_nxt = ST_N1_HI;
      end
      ST_N1_HI: begin
        acc_nxt   = {4'd0, prod_r};
        mul_a     = {17'd0, p_mag_r[46:32]};
        mul_b     = {12'd0, us_r};
        state_nxt = ST_N1_ADD;
      end
      ST_N1_ADD: begin
        acc_nxt   = acc_r + {prod_r[35:0], 32'd0};
        rem_nxt   = 20'd0;
        div_nxt   = US_PER_SEC;
        cnt_nxt   = DIV_LAST;
        state_nxt = ST_DIV_INT;
      end
      ST_DIV_INT, ST_DIV_RATE: begin
        acc_nxt = {acc_r[65:0], ge1, ge2};
        rem_nxt = r2[19:0];
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = (state_r == ST_DIV_INT) ? ST_INTEG : ST_RATE;
        end
      end
      ST_INTEG: begin
        // saturating add of the increment, direction from the sign of p
        isum = {integral_r[63], integral_r}
             + (p_neg_r ? -{17'd0, acc_r[47:0]} : {17'd0, acc_r[47:0]});
        if (isum[64] != isum[63]) begin
          integral_nxt = isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          integral_nxt = $signed(isum[63:0]);
        end
        dp_nxt     = {p_s_r[47], p_s_r} - {last_p_r[47], last_p_r};
        last_p_nxt = p_s_r;
        sum_nxt    = p_neg_r ? -$signed({25'd0, p_mag_r[46:8]})
                             : $signed({25'd0, p_mag_r[46:8]});
        state_nxt  = ST_IMAG;
      end
      ST_IMAG: begin
        opa_nxt    = integral_r[63] ? 64'(-integral_r) : 64'(integral_r);
        tneg_nxt   = integral_r[63] ^ gain_i_r[31];
        term_d_nxt = 1'b0;
        dp_neg_nxt = dp_r[48];
        dp_mag_nxt = dp_r[48] ? 48'(-dp_r) : dp_r[47:0];
        state_nxt  = ST_M24_LO;
      end
      ST_M24_LO: begin
        mul_a     = opa_r[31:0];
        mul_b     = term_d_r ? gd_mag : gi_mag;
        state_nxt = ST_M24_HI;
      end
      ST_M24_HI: begin
        lo_nxt    = prod_r[63:24];
        mul_a     = opa_r[63:32];
        mul_b     = term_d_r ? gd_mag : gi_mag;
        state_nxt = ST_M24_SAT;
      end
      ST_M24_SAT: begin
        if (prod_r > HI_LIM) begin
          term_nxt = TERM_LIM;
        end else begin
          r63 = {1'b0, prod_r[53:0], 8'd0} + {23'd0, lo_r};
          term_nxt = (r63 > {1'b0, TERM_LIM}) ? TERM_LIM : r63[61:0];
        end
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        tval      = tneg_r ? -{2'd0, term_r} : {2'd0, term_r};
        sum_nxt   = sum_r + $signed(tval);
        state_nxt = term_d_r ? ST_FINISH : ST_N2_LO;
      end
      ST_N2_LO: begin
        mul_a     = dp_mag_r[31:0];
        mul_b     = {12'd0, US_PER_SEC};
        state_nxt = ST_N2_HI;
      end
      ST_N2_HI: begin
        acc_nxt   = {4'd0, prod_r};
        mul_a     = {16'd0, dp_mag_r[47:32]};
        mul_b     = {12'd0, US_PER_SEC};
        state_nxt = ST_N2_ADD;
      end
      ST_N2_ADD: begin
        acc_nxt   = acc_r + {prod_r[35:0], 32'd0};
        rem_nxt   = 20'd0;
        div_nxt   = us_r;
        cnt_nxt   = DIV_LAST;
        state_nxt = ST_DIV_RATE;
      end
      ST_RATE: begin
        opa_nxt    = (acc_r > {4'd0, RATE_LIM}) ? RATE_LIM : acc_r[63:0];
        tneg_nxt   = dp_neg_r ^ gain_d_r[31];
        term_d_nxt = 1'b1;
        state_nxt  = ST_M24_LO;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          smag = sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
          mq   = smag[63:16];
          if (sum_r[63]) begin
            drive_nxt = (mq > 48'h0000_8000_0000) ? 32'sh8000_0000 : $signed(-mq[31:0]);
          end else begin
            drive_nxt = (mq > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mq[31:0]);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      integral_r  <= '0;
      last_p_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      integral_r  <= integral_nxt;
      last_p_r    <= last_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_mag_r  <= e_mag_nxt;
    e_neg_r  <= e_neg_nxt;
    us_r     <= us_nxt;
    p_mag_r  <= p_mag_nxt;
    p_neg_r  <= p_neg_nxt;
    p_s_r    <= p_s_nxt;
    dp_r     <= dp_nxt;
    dp_mag_r <= dp_mag_nxt;
    dp_neg_r <= dp_neg_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    cnt_r    <= cnt_nxt;
    opa_r    <= opa_nxt;
    lo_r     <= lo_nxt;
    term_r   <= term_nxt;
    tneg_r   <= tneg_nxt;
    term_d_r <= term_d_nxt;
    sum_r    <= sum_nxt;
    drive_r  <= drive_nxt;
    prod_r   <= mul_a * mul_b;
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_MUL_P)
    else $error("item transfer did not start the sequencer");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_INT || state_r == ST_DIV_RATE) |-> div_r != 20'd0)
    else $error("divider running with zero divisor");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_INT || state_r == ST_DIV_RATE) |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

  a_term_lim: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> term_r <= TERM_LIM)
    else $error("scaled term above its limit");

  a_us_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_P |-> (us_r != 20'd0 && us_r <= US_PER_SEC))
    else $error("interval outside one microsecond to one second");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_chan.ready) |=>
      (state_r == ST_FINISH && $stable(drive_r)))
    else $error("result written over a waiting one");
`endif

endmodule
`default_nettype wire

// ===== sim/pwmi_drive_checker.sv =====
// drive checker: watches the pid channels, predicts each drive value and compares
`timescale 1ns / 1ps
module pwmi_drive_checker
  import pwmi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pwmi_in_if   in_mon,
  pwmi_out_if  out_mon,
  pwmi_cfg_if  cfg_mon,
  output int   mismatches,
  output int   outstanding,
  output int   drives_checked
);

  localparam bit [63:0] USEC_PER_SEC = 64'd1000000;
  localparam bit [63:0] LONG_GAP     = 64'd1000;
  localparam bit [63:0] TERM_CAP     = 64'h2000_0000_0000_0000;
  localparam bit [63:0] RATE_CAP     = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] POS_CAP      = 64'h0000_0000_7FFF_FFFF;
  localparam bit [63:0] NEG_CAP      = 64'h0000_0000_8000_0000;
  localparam longint    ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint    ACC_MIN      = {1'b1, 63'd0};

  longint gain_p_q;
  longint gain_i_q;
  longint gain_d_q;
  longint integral_acc;
  longint prev_prop;
  logic signed [DRIVE_W-1:0] drive_queue [$];
  logic signed [DRIVE_W-1:0] want;

  function automatic bit [63:0] magnitude(input longint x);
    bit [63:0] r;
    r = x;
    if (x < 0) r = -r;
    return r;
  endfunction

  function automatic longint apply_sign(input bit neg, input bit [63:0] m);
    longint v;
    v = signed'(m);
    return neg ? -v : v;
  endfunction

  // (a * b) / 2^24 with the term cap
  function automatic bit [63:0] scale_q24(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] r;
    hi = {32'd0, a[63:32]} * b;
    lo = {32'd0, a[31:0]} * b;
    if (hi > (TERM_CAP >> 8)) return TERM_CAP;
    r = (hi << 8) + (lo >> 24);
    return (r > TERM_CAP) ? TERM_CAP : r;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] next_drive(
    input logic signed [TILT_W-1:0] tgt,
    input logic signed [TILT_W-1:0] mea,
    input logic        [US_W-1:0]   elapsed
  );
    longint    err;
    longint    prop;
    longint    dprop;
    longint    p_term;
    longint    i_term;
    longint    d_term;
    longint    total;
    longint    wide;
    bit [63:0] usec;
    bit [63:0] mag;
    bit [63:0] quo;
    bit [63:0] rem;
    bit [63:0] step;
    bit [63:0] rate;
    usec = elapsed;
    if (usec > USEC_PER_SEC) usec = LONG_GAP;
    if (usec == 0) usec = 64'd1;
    err  = longint'(tgt) - longint'(mea);
    prop = err * gain_p_q;

    // integral step p * us / 1e6, truncated toward zero
    mag  = magnitude(prop);
    quo  = mag / USEC_PER_SEC;
    rem  = mag % USEC_PER_SEC;
    step = quo * usec + (rem * usec) / USEC_PER_SEC;
    if (prop >= 0) begin
      if (integral_acc > ACC_MAX - signed'(step)) integral_acc = ACC_MAX;
      else integral_acc = integral_acc + signed'(step);
    end else begin
      if (integral_acc < ACC_MIN + signed'(step)) integral_acc = ACC_MIN;
      else integral_acc = integral_acc - signed'(step);
    end

    // derivative rate dp * 1e6 / us
    dprop = prop - prev_prop;
    mag   = magnitude(dprop);
    quo   = mag / usec;
    rem   = mag % usec;
    if (quo > RATE_CAP / USEC_PER_SEC) begin
      rate = RATE_CAP;
    end else begin
      rate = quo * USEC_PER_SEC + (rem * USEC_PER_SEC) / usec;
      if (rate > RATE_CAP) rate = RATE_CAP;
    end
    prev_prop = prop;

    p_term = apply_sign(prop < 0, magnitude(prop) >> 8);
    i_term = apply_sign((integral_acc < 0) != (gain_i_q < 0),
                        scale_q24(magnitude(integral_acc), magnitude(gain_i_q)));
    d_term = apply_sign((dprop < 0) != (gain_d_q < 0),
                        scale_q24(rate, magnitude(gain_d_q)));
    total  = p_term + i_term + d_term;
    mag    = magnitude(total) >> 16;
    if (total < 0) begin
      if (mag > NEG_CAP) mag = NEG_CAP;
      wide = -signed'(mag);
    end else begin
      if (mag > POS_CAP) mag = POS_CAP;
      wide = signed'(mag);
    end
    return wide[DRIVE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_p_q       = 0;
      gain_i_q       = 0;
      gain_d_q       = 0;
      integral_acc   = 0;
      prev_prop      = 0;
      drive_queue.delete();
      mismatches     <= 0;
      outstanding    <= 0;
      drives_checked <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_GAIN_P: gain_p_q = signed'(cfg_mon.data);
          REG_GAIN_I: gain_i_q = signed'(cfg_mon.data);
          REG_GAIN_D: gain_d_q = signed'(cfg_mon.data);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        drive_queue.push_back(next_drive(in_mon.target_tilt, in_mon.measured_tilt,
                                         in_mon.elapsed_us));
      if (out_mon.valid && out_mon.ready) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected drive %0d, nothing outstanding", $time, out_mon.drive);
          mismatches <= mismatches + 1;
        end else begin
          want = drive_queue.pop_front();
          if (out_mon.drive !== want) begin
            $display("%0t: drive mismatch, expected %0d, got %0d", $time, want, out_mon.drive);
            mismatches <= mismatches + 1;
          end
          drives_checked <= drives_checked + 1;
        end
      end
      outstanding <= drive_queue.size();
    end
  end

endmodule

// ===== sim/pid_with_measured_interval_tb.sv =====
// top of the pid testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module pid_with_measured_interval_tb;
  import pwmi_pkg::*;

  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 1500;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 220;
  localparam int WINDUP_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   drives_checked;
  int   items_sent;
  int   gain_sets;
  int   burst_left;
  int   idle_cycles;
  int   tilt_bias;
  logic hold_request;
  logic hold_done;

  pwmi_in_if  in_chan ();
  pwmi_out_if out_chan ();
  pwmi_cfg_if cfg_chan ();

  pid_with_measured_interval dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  pwmi_drive_checker u_drive_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_mon        (cfg_chan),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .drives_checked (drives_checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls on its own pattern, with one long hold-off on request
  initial begin : receiver
    int span;
    int mode;
    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= 1'($urandom_range(0, 1));
          2: out_chan.ready <= (k % 4 == 3);
          default: out_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer_item(input int tgt, input int mea, input int us);
    in_chan.valid         <= 1'b1;
    in_chan.target_tilt   <= tgt[TILT_W-1:0];
    in_chan.measured_tilt <= mea[TILT_W-1:0];
    in_chan.elapsed_us    <= us[US_W-1:0];
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_chan.valid <= 1'b0;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 8)) @(posedge clk);
      else repeat ($urandom_range(9, 150)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                            input logic [GAIN_W-1:0] kd);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    if ($urandom_range(0, 1)) write_reg(REG_SPARE, $urandom());
    cfg_chan.valid <= 1'b0;
    gain_sets++;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return '0;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  task automatic random_item();
    int t;
    int m;
    int us;
    case ($urandom_range(0, 9)) inside
      0, 1: begin
        t = $urandom_range(0, 65535);
        m = $urandom_range(0, 65535);
      end
      8, 9: begin
        t = $urandom_range(0, 1) ? 32767 : -32768;
        m = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 32767 : -32768);
      end
      default: begin
        // steady offset with noise so the integral builds up
        t = int'($urandom_range(0, 40000)) - 20000;
        m = t - tilt_bias + int'($urandom_range(0, 512)) - 256;
      end
    endcase
    case ($urandom_range(0, 9))
      5: us = int'($urandom());
      6: us = $urandom_range(0, 1);
      7: us = 999997 + $urandom_range(0, 6);
      8: us = $urandom_range(1000001, 16777215);
      9: us = $urandom_range(1, 999);
      default: us = $urandom_range(1, 20000);
    endcase
    offer_item(t, m, us);
  endtask

  initial begin : stimulus
    rst_n                 <= 1'b0;
    hold_request          <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.target_tilt   <= '0;
    in_chan.measured_tilt <= '0;
    in_chan.elapsed_us    <= '0;
    cfg_chan.valid        <= 1'b0;
    cfg_chan.index        <= '0;
    cfg_chan.data         <= '0;
    items_sent = 0;
    gain_sets  = 0;
    burst_left = 0;
    tilt_bias  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // interval edges: zero, one, just under and over a second, full width
    load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
    offer_item(0, 0, 1000);
    offer_item(32767, -32768, 1000);
    offer_item(-32768, 32767, 1000);
    offer_item(100, -100, 0);
    offer_item(100, -100, 1);
    offer_item(-256, 256, 1000000);
    offer_item(-256, 256, 1000001);
    offer_item(512, 0, 16777215);
    offer_item(32767, 32767, 999999);
    offer_item(0, -32768, 500);
    drain_results();

    // largest gains, drive saturates both ways
    load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    cfg_chan.valid <= 1'b0;
    offer_item(32767, -32768, 1);
    offer_item(-32768, 32767, 0);
    offer_item(0, 0, 1000);
    drain_results();

    load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_item(32767, -32768, 1000000);
    offer_item(-32768, 32767, 1);
    offer_item(1, 0, 16777215);
    drain_results();

    load_gains('0, '0, '0);
    offer_item(32767, -32768, 1);
    offer_item(-1, 0, 1000);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_gains(pick_gain(), pick_gain(), pick_gain());
      tilt_bias = int'($urandom_range(0, 8192)) - 4096;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 60) hold_request <= 1'b1;
        random_item();
      end
      drain_results();
    end

    // integral windup until the integral term saturates, then unwind a little
    load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    for (int n = 0; n < WINDUP_ITEMS; n++) offer_item(32767, -32768, 1000000);
    for (int n = 0; n < 10; n++) offer_item(-32768, 32767, 1000);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d items, %0d drive transfers checked, %0d gain settings",
             items_sent, drives_checked, gain_sets);
    $display("interval edges, saturation, integral windup and a long output hold-off (%0d)",
             hold_done);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
